// ===== rtl/mtpc_pkg.sv =====
// Shared types, codes and widths for the MAC transmit pause controller.
// No dependencies; every other file uses it by scoped names.
package mtpc_pkg;

   localparam int COUNT_W     = 26;
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [1:0] {
      CMD_TICK  = 2'd0,
      CMD_FRAME = 2'd1,
      CMD_DONE  = 2'd2,
      CMD_PAUSE = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_LINK_DOWN = 2'd1,
      STATUS_OVERSIZE  = 2'd2,
      STATUS_ILLEGAL   = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      TX_STATE_IDLE  = 2'd0,
      TX_STATE_TX    = 2'd1,
      TX_STATE_IFG   = 2'd2,
      TX_STATE_PAUSE = 2'd3
   } tx_state_type;

   typedef enum logic [2:0] {
      CSR_LINK_UP        = 3'd0,
      CSR_BITS_PER_TICK  = 3'd1,
      CSR_IFG_BITS       = 3'd2,
      CSR_PAUSE_QUANTUM  = 3'd3,
      CSR_MAX_FRAME      = 3'd4
   } csr_index_type;

   typedef enum logic [3:0] {
      MODE_IDLE  = 4'b0001,
      MODE_TX    = 4'b0010,
      MODE_IFG   = 4'b0100,
      MODE_PAUSE = 4'b1000
   } mode_type;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [13:0] frame_bytes;
      logic [15:0] pause_quanta;
   } req_type;

   typedef struct packed {
      logic [1:0]  tx_state;
      logic        start_tx;
      logic [1:0]  status;
      logic [15:0] pending_quanta;
      logic        ready_res;
   } rsp_type;

   typedef struct packed {
      logic        link_up;
      logic [6:0]  bits_per_tick;
      logic [10:0] ifg_bits;
      logic [10:0] pause_quantum_bits;
      logic [13:0] max_frame_bytes;
   } cfg_type;

   typedef struct packed {
      cmd_type              cmd;
      logic                 oversize;
      logic                 link_down;
      logic                 quanta_zero;
      logic [15:0]          quanta;
      logic [COUNT_W-1:0]   pause_len;
   } item_type;

endpackage

// ===== rtl/mac_tx_pause_controller.sv =====
// Top level of the MAC transmit pause controller: configuration registers,
// front end, item queue and back end. Depends on mtpc_pkg and all rtl modules.
//
// Full-duplex MAC transmit controller with pause flow control. Each request
// (tick, frame request, transmit done, pause received) yields one response
// carrying the state after the event, a start flag, a status code and the
// deferred pause quanta. Requests are taken one per clock, sustained, while
// the response side keeps popping; a response reaches the response ports
// through the queue and then the back end's response register. The back end
// retires one queued item per clock into that register while it is free or popped.
// The queue between front and back end takes QUEUE_DEPTH further requests
// while the response side stalls. Configuration writes are always
// accepted and must be made while no request is in flight.
module mac_tx_pause_controller #(
   parameter int QUEUE_DEPTH = mtpc_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   input  mtpc_pkg::req_type req_payload,
   output logic              req_full,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output mtpc_pkg::rsp_type rsp_payload,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [2:0]        csr_index,
   input  logic [13:0]       csr_data
);

   mtpc_pkg::cfg_type  cfg_ff, cfg_in;
   mtpc_pkg::item_type front_item;
   mtpc_pkg::item_type queue_item;
   logic               queue_empty;
   logic               queue_pop;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            mtpc_pkg::CSR_LINK_UP:       cfg_in.link_up            = csr_data[0];
            mtpc_pkg::CSR_BITS_PER_TICK: cfg_in.bits_per_tick      = csr_data[6:0];
            mtpc_pkg::CSR_IFG_BITS:      cfg_in.ifg_bits           = csr_data[10:0];
            mtpc_pkg::CSR_PAUSE_QUANTUM: cfg_in.pause_quantum_bits = csr_data[10:0];
            mtpc_pkg::CSR_MAX_FRAME:     cfg_in.max_frame_bytes    = csr_data[13:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.link_up            <= 1'b1;
         cfg_ff.bits_per_tick      <= 7'd8;
         cfg_ff.ifg_bits           <= 11'd96;
         cfg_ff.pause_quantum_bits <= 11'd512;
         cfg_ff.max_frame_bytes    <= 14'd1518;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   mtpc_front u_front (
      .req  (req_payload),
      .cfg  (cfg_ff),
      .item (front_item)
   );

   mtpc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_data (front_item),
      .full      (req_full),
      .pop       (queue_pop),
      .pop_data  (queue_item),
      .empty     (queue_empty)
   );

   mtpc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .item       (queue_item),
      .item_empty (queue_empty),
      .item_pop   (queue_pop),
      .rsp        (rsp_payload),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop)
   );

`ifndef NO_ASSERTIONS
   a_ready_matches_state: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_payload.ready_res ==
                      (rsp_payload.tx_state == mtpc_pkg::TX_STATE_IDLE)))
      else $error("ready_res disagrees with tx_state");

   a_start_is_clean: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_payload.start_tx) |->
         (rsp_payload.status == mtpc_pkg::STATUS_OK &&
          rsp_payload.tx_state == mtpc_pkg::TX_STATE_TX))
      else $error("frame start with bad status or state");

   a_reset_empties: assert property (@(posedge clock)
      reset |=> (rsp_empty && !req_full))
      else $error("queues not empty after reset");

   a_retire_fills_output: assert property (@(posedge clock) disable iff (reset)
      queue_pop |=> !rsp_empty)
      else $error("retired item produced no response");
`endif

endmodule

// ===== rtl/mtpc_front.sv =====
// Front end: decodes an accepted request, checks it against the frame limits
// and works out the saturated pause length. Depends on mtpc_pkg.
module mtpc_front (
   input  mtpc_pkg::req_type  req,
   input  mtpc_pkg::cfg_type  cfg,
   output mtpc_pkg::item_type item
);

   logic [mtpc_pkg::COUNT_W:0] product;

   assign product = (mtpc_pkg::COUNT_W + 1)'(req.pause_quanta)
                  * (mtpc_pkg::COUNT_W + 1)'(cfg.pause_quantum_bits);

   always_comb begin
      item.cmd         = mtpc_pkg::cmd_type'(req.cmd);
      item.oversize    = req.frame_bytes > cfg.max_frame_bytes;
      item.link_down   = !cfg.link_up;
      item.quanta_zero = req.pause_quanta == 16'd0;
      item.quanta      = req.pause_quanta;
      item.pause_len   = product[mtpc_pkg::COUNT_W] ? '1
                                                    : product[mtpc_pkg::COUNT_W-1:0];
   end

endmodule

// ===== rtl/mtpc_queue.sv =====
// Small queue of classified items between front and back end.
// Depends on mtpc_pkg for the item type.
module mtpc_queue #(
   parameter int DEPTH = mtpc_pkg::QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  mtpc_pkg::item_type push_data,
   output logic               full,
   input  logic               pop,
   output mtpc_pkg::item_type pop_data,
   output logic               empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   mtpc_pkg::item_type mem [DEPTH];

   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff,  count_in;
   logic             do_push, do_pop;

   assign full     = count_ff == CNT_W'(DEPTH);
   assign empty    = count_ff == '0;
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/mtpc_back.sv =====
// Back end: transmit state machine, bit countdown, deferred pause and the
// result register. Depends on mtpc_pkg.
module mtpc_back (
   input  logic               clock,
   input  logic               reset,
   input  mtpc_pkg::cfg_type  cfg,
   input  mtpc_pkg::item_type item,
   input  logic               item_empty,
   output logic               item_pop,
   output mtpc_pkg::rsp_type  rsp,
   output logic               rsp_empty,
   input  logic               rsp_pop
);

   localparam int CW = mtpc_pkg::COUNT_W;

   mtpc_pkg::mode_type   mode_ff, mode_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [15:0]          deferred_ff, deferred_in;
   logic [CW:0]          deferred_prod;
   logic [CW-1:0]        deferred_len;
   logic                 out_valid_ff, out_valid_in;
   mtpc_pkg::rsp_type    out_ff, out_in;
   logic                 start;
   mtpc_pkg::status_type status;
   logic [CW-1:0]        step;
   logic [1:0]           state_code;

   assign item_pop  = !item_empty && (!out_valid_ff || rsp_pop);
   assign rsp_empty = !out_valid_ff;
   assign rsp       = out_ff;
   assign step      = CW'(cfg.bits_per_tick);

   // deferred pause length uses the quantum size in force at transmit end
   assign deferred_prod = (CW + 1)'(deferred_ff) * (CW + 1)'(cfg.pause_quantum_bits);
   assign deferred_len  = deferred_prod[CW] ? '1 : deferred_prod[CW-1:0];

   always_comb begin
      mode_in         = mode_ff;
      count_in        = count_ff;
      deferred_in     = deferred_ff;
      start           = 1'b0;
      status          = mtpc_pkg::STATUS_OK;
      unique case (item.cmd)
         mtpc_pkg::CMD_TICK: begin
            if (mode_ff == mtpc_pkg::MODE_IFG || mode_ff == mtpc_pkg::MODE_PAUSE) begin
               if (count_ff <= step) begin
                  count_in = '0;
                  mode_in  = mtpc_pkg::MODE_IDLE;
               end else begin
                  count_in = count_ff - step;
               end
            end
         end
         mtpc_pkg::CMD_FRAME: begin
            priority if (item.oversize) begin
               status = mtpc_pkg::STATUS_OVERSIZE;
            end else if (item.link_down) begin
               status = mtpc_pkg::STATUS_LINK_DOWN;
            end else if (mode_ff != mtpc_pkg::MODE_IDLE) begin
               status = mtpc_pkg::STATUS_ILLEGAL;
            end else begin
               mode_in = mtpc_pkg::MODE_TX;
               start   = 1'b1;
            end
         end
         mtpc_pkg::CMD_DONE: begin
            priority if (mode_ff != mtpc_pkg::MODE_TX) begin
               status = mtpc_pkg::STATUS_ILLEGAL;
            end else if (deferred_ff != 16'd0) begin
               count_in        = deferred_len;
               mode_in         = mtpc_pkg::MODE_PAUSE;
               deferred_in     = 16'd0;
            end else begin
               count_in = CW'(cfg.ifg_bits);
               mode_in  = mtpc_pkg::MODE_IFG;
            end
         end
         mtpc_pkg::CMD_PAUSE: begin
            priority if (mode_ff == mtpc_pkg::MODE_IDLE) begin
               if (!item.quanta_zero) begin
                  count_in = item.pause_len;
                  mode_in  = mtpc_pkg::MODE_PAUSE;
               end
            end else if (mode_ff == mtpc_pkg::MODE_PAUSE) begin
               if (item.quanta_zero) begin
                  count_in = '0;
                  mode_in  = mtpc_pkg::MODE_IDLE;
               end else begin
                  count_in = item.pause_len;
               end
            end else begin
               deferred_in     = item.quanta;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      unique case (mode_in)
         mtpc_pkg::MODE_IDLE:  state_code = mtpc_pkg::TX_STATE_IDLE;
         mtpc_pkg::MODE_TX:    state_code = mtpc_pkg::TX_STATE_TX;
         mtpc_pkg::MODE_IFG:   state_code = mtpc_pkg::TX_STATE_IFG;
         mtpc_pkg::MODE_PAUSE: state_code = mtpc_pkg::TX_STATE_PAUSE;
         default:              state_code = mtpc_pkg::TX_STATE_IDLE;
      endcase
      out_in.tx_state       = state_code;
      out_in.start_tx       = start;
      out_in.status         = status;
      out_in.pending_quanta = deferred_in;
      out_in.ready_res      = mode_in == mtpc_pkg::MODE_IDLE;
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (item_pop) begin
         out_valid_in = 1'b1;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff         <= mtpc_pkg::MODE_IDLE;
         count_ff        <= '0;
         deferred_ff     <= 16'd0;
         out_valid_ff    <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (item_pop) begin
            mode_ff         <= mode_in;
            count_ff        <= count_in;
            deferred_ff     <= deferred_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (item_pop) begin
         out_ff <= out_in;
      end
   end

endmodule
